// ----- sv/wola3_pkg.sv -----
package wola3_pkg;

    localparam int NUM_CH     = 3;
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 16;
    localparam int HOP_W      = 11;
    localparam int GAIN_W     = 16;
    localparam int SUM_W      = 40;
    localparam int WSQ_W      = 43;
    localparam int PROD_W     = SAMPLE_W + COEF_W + 1;
    localparam int WPROD_W    = 2 * COEF_W;
    localparam int MAG_GAIN_W = SUM_W + GAIN_W;
    // Numerator is mag * gain * 16 plus half the divisor.
    localparam int NUM_W      = MAG_GAIN_W + 4 + 1;
    localparam int Q_W        = 17;
    localparam int REM_W      = NUM_W - Q_W;
    localparam int DIV_CNT_W  = $clog2(Q_W);

    localparam int FRAME_LENGTH_DEF = 1024;

    localparam logic [HOP_W-1:0]  HOP_RESET  = 11'd256;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;

    localparam logic [WSQ_W-1:0] NORM_FLOOR = 43'd4294;
    localparam logic [WSQ_W-1:0] NORM_ONE   = 43'h001_0000_0000;

    localparam logic [Q_W-1:0] Q_POS_LIMIT = 17'd32767;
    localparam logic [Q_W-1:0] Q_NEG_LIMIT = 17'd32768;

    localparam logic signed [SAMPLE_W-1:0] OUT_MAX = 16'sh7FFF;
    localparam logic signed [SAMPLE_W-1:0] OUT_MIN = 16'sh8000;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
    localparam logic [WSQ_W-1:0]        WSQ_MAX = {WSQ_W{1'b1}};

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HOP_SIZE    = 1'b0,
        REG_OUTPUT_GAIN = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RDSRC,
        S_PREP,
        S_WRITE,
        S_DIV,
        S_OUT
    } state_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    // One overlap position: the three channel sums and the window-square sum.
    typedef struct packed {
        sum_t [NUM_CH-1:0]  sum;
        logic [WSQ_W-1:0]   wsq;
    } entry_t;

endpackage

// ----- sv/weighted_overlap_add_three_channel_unit.sv -----
// A sample item reads the store twice and writes it back; when an output is due, the
// 17-step restoring divider (three lanes in lockstep) follows, and the item may then wait
// while the previous output is still held. No new item is taken until the current one is done.
// Reset (asynchronous, active low) and the clear op start a clearing pass over
// every position that zeroes the store; no item is taken during it.
// Configuration writes are taken at any cycle and belong between items.
module weighted_overlap_add_three_channel_unit #(
    parameter int FRAME_LENGTH = wola3_pkg::FRAME_LENGTH_DEF
) (
    input  logic                                    clk,
    input  logic                                    rst_n,

    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic                                    op,
    input  logic signed [wola3_pkg::SAMPLE_W-1:0]   fund_in,
    input  logic signed [wola3_pkg::SAMPLE_W-1:0]   prime_in,
    input  logic signed [wola3_pkg::SAMPLE_W-1:0]   comp_in,
    input  logic        [wola3_pkg::COEF_W-1:0]     window_coef,
    input  logic                                    frame_last,

    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic signed [wola3_pkg::SAMPLE_W-1:0]   fund_out,
    output logic signed [wola3_pkg::SAMPLE_W-1:0]   prime_out,
    output logic signed [wola3_pkg::SAMPLE_W-1:0]   comp_out,
    output logic                                    hop_last,

    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic        [wola3_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [wola3_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int NUM_CH     = wola3_pkg::NUM_CH;
    localparam int SAMPLE_W   = wola3_pkg::SAMPLE_W;
    localparam int COEF_W     = wola3_pkg::COEF_W;
    localparam int HOP_W      = wola3_pkg::HOP_W;
    localparam int GAIN_W     = wola3_pkg::GAIN_W;
    localparam int SUM_W      = wola3_pkg::SUM_W;
    localparam int WSQ_W      = wola3_pkg::WSQ_W;
    localparam int PROD_W     = wola3_pkg::PROD_W;
    localparam int WPROD_W    = wola3_pkg::WPROD_W;
    localparam int MAG_GAIN_W = wola3_pkg::MAG_GAIN_W;
    localparam int NUM_W      = wola3_pkg::NUM_W;
    localparam int Q_W        = wola3_pkg::Q_W;
    localparam int REM_W      = wola3_pkg::REM_W;
    localparam int DIV_CNT_W  = wola3_pkg::DIV_CNT_W;

    localparam int POS_W = (FRAME_LENGTH > 1) ? $clog2(FRAME_LENGTH) : 1;
    localparam int SRC_W = ((POS_W > HOP_W) ? POS_W : HOP_W) + 1;

    localparam logic [POS_W-1:0]     POS_LAST = POS_W'(FRAME_LENGTH - 1);
    localparam logic [SRC_W-1:0]     SRC_END  = SRC_W'(FRAME_LENGTH);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(Q_W - 1);

    // ---------------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------------
    wola3_pkg::state_t state_reg, state_next;

    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [POS_W-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 out_valid_reg, out_valid_next;
    logic [HOP_W-1:0]     hop_reg;
    logic [GAIN_W-1:0]    gain_reg;

    // ---------------------------------------------------------------------
    // Item and datapath registers
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0]   x_reg [NUM_CH];
    logic [COEF_W-1:0]            w_reg;
    logic                         last_reg;
    logic signed [PROD_W-1:0]     prod_reg [NUM_CH];
    logic [WPROD_W-1:0]           wprod_reg;
    logic [MAG_GAIN_W-1:0]        mg_reg [NUM_CH];
    logic                         neg_reg [NUM_CH];
    logic [WSQ_W-1:0]             norm_reg;
    wola3_pkg::entry_t            wdata_reg;
    logic [WSQ_W-1:0]             rem_reg [NUM_CH];
    logic [Q_W-1:0]               numlo_reg [NUM_CH];
    logic [Q_W-1:0]               q_reg [NUM_CH];
    logic                         sat_reg [NUM_CH];
    logic                         hop_last_reg;
    logic signed [SAMPLE_W-1:0]   out_data_reg [NUM_CH];
    logic                         out_hop_last_reg;

    // ---------------------------------------------------------------------
    // Overlap store
    // ---------------------------------------------------------------------
    wola3_pkg::entry_t ola_mem [FRAME_LENGTH];
    wola3_pkg::entry_t mem_rdata_reg;
    wola3_pkg::entry_t mem_wdata;
    logic              mem_we;
    logic              mem_re;
    logic [POS_W-1:0]  mem_waddr;
    logic [POS_W-1:0]  mem_raddr;

    logic              in_accept;
    logic              out_load;
    logic              cfg_accept;

    logic [SRC_W-1:0]  pos_ext;
    logic [SRC_W-1:0]  hop_ext;
    logic [SRC_W-1:0]  src;
    logic              src_ok;
    logic              emit;
    logic              pos_wrap;
    logic              hop_last_calc;

    assign in_accept  = in_valid && in_ready;
    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    assign pos_ext  = SRC_W'(pos_reg);
    assign hop_ext  = SRC_W'(hop_reg);
    assign src      = pos_ext + hop_ext;
    assign src_ok   = (src < SRC_END);
    assign emit     = (pos_ext < hop_ext);
    assign pos_wrap = last_reg || (pos_reg == POS_LAST);
    assign hop_last_calc = ((pos_ext + SRC_W'(1)) == hop_ext) || pos_wrap;

    // ---------------------------------------------------------------------
    // Next-state logic
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            wola3_pkg::S_CLEAR:
            begin
                if (clr_cnt_reg == POS_LAST)
                begin
                    state_next = wola3_pkg::S_IDLE;
                end
            end
            wola3_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    if (op == wola3_pkg::OP_CLEAR)
                    begin
                        state_next = wola3_pkg::S_CLEAR;
                    end
                    else
                    begin
                        state_next = wola3_pkg::S_RDSRC;
                    end
                end
            end
            wola3_pkg::S_RDSRC:
            begin
                state_next = wola3_pkg::S_PREP;
            end
            wola3_pkg::S_PREP:
            begin
                state_next = wola3_pkg::S_WRITE;
            end
            wola3_pkg::S_WRITE:
            begin
                state_next = emit ? wola3_pkg::S_DIV : wola3_pkg::S_IDLE;
            end
            wola3_pkg::S_DIV:
            begin
                if (div_cnt_reg == DIV_LAST)
                begin
                    state_next = wola3_pkg::S_OUT;
                end
            end
            wola3_pkg::S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = wola3_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = wola3_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control outputs
    // ---------------------------------------------------------------------
    always_comb
    begin
        in_ready     = 1'b0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = pos_reg;
        mem_raddr    = pos_reg;
        mem_wdata    = wdata_reg;
        out_load     = 1'b0;
        pos_next     = pos_reg;
        clr_cnt_next = clr_cnt_reg;
        div_cnt_next = div_cnt_reg;
        unique case (state_reg)
            wola3_pkg::S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_waddr    = clr_cnt_reg;
                mem_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + POS_W'(1);
            end
            wola3_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                clr_cnt_next = '0;
                // The entry at the current position is fetched as the item lands.
                mem_re       = in_accept && (op == wola3_pkg::OP_SAMPLE);
                if (in_accept && (op == wola3_pkg::OP_CLEAR))
                begin
                    pos_next = '0;
                end
            end
            wola3_pkg::S_RDSRC:
            begin
                mem_re    = src_ok;
                mem_raddr = src[POS_W-1:0];
            end
            wola3_pkg::S_PREP:
            begin
            end
            wola3_pkg::S_WRITE:
            begin
                mem_we       = 1'b1;
                div_cnt_next = '0;
                pos_next     = pos_wrap ? '0 : pos_reg + POS_W'(1);
            end
            wola3_pkg::S_DIV:
            begin
                div_cnt_next = div_cnt_reg + DIV_CNT_W'(1);
            end
            wola3_pkg::S_OUT:
            begin
                out_load = !out_valid_reg || out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= wola3_pkg::S_CLEAR;
            pos_reg       <= '0;
            clr_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            hop_reg       <= wola3_pkg::HOP_RESET;
            gain_reg      <= wola3_pkg::GAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            clr_cnt_reg   <= clr_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_accept)
            begin
                unique case (wola3_pkg::cfg_reg_t'(cfg_index))
                    wola3_pkg::REG_HOP_SIZE:    hop_reg  <= cfg_data[HOP_W-1:0];
                    wola3_pkg::REG_OUTPUT_GAIN: gain_reg <= cfg_data[GAIN_W-1:0];
                    default:                    hop_reg  <= hop_reg;
                endcase
            end
        end
    end

    // ---------------------------------------------------------------------
    // Store: one write port, one registered read port. Each item reads and
    // writes in distinct cycles and the next item reads only after the
    // write-back, so no forwarding is needed.
    // ---------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ola_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata_reg <= ola_mem[mem_raddr];
        end
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    logic signed [SAMPLE_W-1:0]   x_in [NUM_CH];
    logic signed [SUM_W-1:0]      old_n_sum [NUM_CH];
    logic [SUM_W-1:0]             mag [NUM_CH];
    logic signed [PROD_W-1:0]     prod [NUM_CH];
    logic [WSQ_W-1:0]             norm;
    wola3_pkg::entry_t            old_src;
    logic signed [SUM_W:0]        sum_ext [NUM_CH];
    wola3_pkg::entry_t            new_entry;
    logic [WSQ_W:0]               wsq_ext;
    logic [NUM_W-1:0]             num [NUM_CH];
    logic [REM_W-1:0]             rem_init [NUM_CH];
    logic                         sat_init [NUM_CH];
    logic [REM_W-1:0]             trial [NUM_CH];
    logic [REM_W-1:0]             diff [NUM_CH];
    logic                         ge [NUM_CH];
    logic [WSQ_W-1:0]             rem_step [NUM_CH];
    logic signed [SAMPLE_W-1:0]   out_val [NUM_CH];

    assign x_in[0] = fund_in;
    assign x_in[1] = prime_in;
    assign x_in[2] = comp_in;

    always_comb
    begin
        norm = (mem_rdata_reg.wsq <= wola3_pkg::NORM_FLOOR) ?
               wola3_pkg::NORM_ONE : mem_rdata_reg.wsq;
        old_src   = src_ok ? mem_rdata_reg : '0;
        wsq_ext   = {1'b0, old_src.wsq} + (WSQ_W + 1)'(wprod_reg);
        new_entry = '0;
        new_entry.wsq = wsq_ext[WSQ_W] ? wola3_pkg::WSQ_MAX : wsq_ext[WSQ_W-1:0];
        for (int c = 0; c < NUM_CH; c++)
        begin
            // Lookup of position n (fetched on accept), for the output.
            old_n_sum[c] = $signed(mem_rdata_reg.sum[c]);
            mag[c] = old_n_sum[c][SUM_W-1] ? (~old_n_sum[c] + SUM_W'(1)) : old_n_sum[c];
            prod[c] = $signed({{(PROD_W-SAMPLE_W){x_reg[c][SAMPLE_W-1]}}, x_reg[c]}) *
                      $signed({{(PROD_W-COEF_W){1'b0}}, w_reg});

            // Lookup of position n + hop, shifted down into position n.
            sum_ext[c] = $signed({old_src.sum[c][SUM_W-1], old_src.sum[c]}) +
                         $signed({{(SUM_W+1-PROD_W){prod_reg[c][PROD_W-1]}}, prod_reg[c]});
            if (sum_ext[c][SUM_W] != sum_ext[c][SUM_W-1])
            begin
                new_entry.sum[c] = sum_ext[c][SUM_W] ? wola3_pkg::SUM_MIN : wola3_pkg::SUM_MAX;
            end
            else
            begin
                new_entry.sum[c] = sum_ext[c][SUM_W-1:0];
            end

            // Rounded numerator; a quotient of 2^Q_W or more only saturates.
            num[c] = NUM_W'({mg_reg[c], 4'b0000}) + NUM_W'(norm_reg >> 1);
            rem_init[c] = num[c][NUM_W-1:Q_W];
            sat_init[c] = (rem_init[c] >= REM_W'(norm_reg));

            // One restoring division step per cycle.
            trial[c]    = {rem_reg[c], numlo_reg[c][Q_W-1]};
            ge[c]       = (trial[c] >= REM_W'(norm_reg));
            diff[c]     = trial[c] - REM_W'(norm_reg);
            rem_step[c] = ge[c] ? diff[c][WSQ_W-1:0] : trial[c][WSQ_W-1:0];

            if (neg_reg[c])
            begin
                out_val[c] = (sat_reg[c] || (q_reg[c] > wola3_pkg::Q_NEG_LIMIT)) ?
                             wola3_pkg::OUT_MIN : $signed(SAMPLE_W'(Q_W'(0) - q_reg[c]));
            end
            else
            begin
                out_val[c] = (sat_reg[c] || (q_reg[c] > wola3_pkg::Q_POS_LIMIT)) ?
                             wola3_pkg::OUT_MAX : $signed(q_reg[c][SAMPLE_W-1:0]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                x_reg[c] <= x_in[c];
            end
            w_reg    <= window_coef;
            last_reg <= frame_last;
        end
        if (state_reg == wola3_pkg::S_RDSRC)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                prod_reg[c] <= prod[c];
                mg_reg[c]   <= MAG_GAIN_W'(mag[c]) * MAG_GAIN_W'(gain_reg);
                neg_reg[c]  <= old_n_sum[c][SUM_W-1];
            end
            wprod_reg <= WPROD_W'(w_reg) * WPROD_W'(w_reg);
            norm_reg  <= norm;
        end
        if (state_reg == wola3_pkg::S_PREP)
        begin
            wdata_reg <= new_entry;
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_reg[c]   <= rem_init[c][WSQ_W-1:0];
                numlo_reg[c] <= num[c][Q_W-1:0];
                sat_reg[c]   <= sat_init[c];
                q_reg[c]     <= '0;
            end
        end
        if (state_reg == wola3_pkg::S_WRITE)
        begin
            hop_last_reg <= hop_last_calc;
        end
        if (state_reg == wola3_pkg::S_DIV)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                rem_reg[c]   <= rem_step[c];
                numlo_reg[c] <= {numlo_reg[c][Q_W-2:0], 1'b0};
                q_reg[c]     <= {q_reg[c][Q_W-2:0], ge[c]};
            end
        end
        if (out_load)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                out_data_reg[c] <= out_val[c];
            end
            out_hop_last_reg <= hop_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign fund_out  = out_data_reg[0];
    assign prime_out = out_data_reg[1];
    assign comp_out  = out_data_reg[2];
    assign hop_last  = out_hop_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_read_write_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mem_re))
        else $error("store read and written in the same cycle");

    a_pos_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LAST)
        else $error("frame position beyond frame length");

    a_div_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == wola3_pkg::S_DIV) |-> (div_cnt_reg <= DIV_LAST))
        else $error("divider ran past its last step");

    a_out_from_div: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == wola3_pkg::S_OUT))
        else $error("output item raised outside the output state");

endmodule

// ----- tb/sv/tb_weighted_overlap_add_three_channel_unit.sv -----
`timescale 1ns / 100ps

module tb_weighted_overlap_add_three_channel_unit;

    localparam int FRAME_LEN    = wola3_pkg::FRAME_LENGTH_DEF;
    localparam int NUM_CH       = wola3_pkg::NUM_CH;
    localparam int SAMPLE_W     = wola3_pkg::SAMPLE_W;
    localparam int COEF_W       = wola3_pkg::COEF_W;
    localparam int HOP_W        = wola3_pkg::HOP_W;
    localparam int CFG_DATA_W   = wola3_pkg::CFG_DATA_W;
    localparam int LONG_HOLD    = 400;
    localparam int SETTLE_CYC   = 40;
    localparam int RANDOM_ITEMS = 300;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef struct {
        wola3_pkg::op_t    op;
        sample_t           fund;
        sample_t           prime;
        sample_t           comp;
        logic [COEF_W-1:0] coef;
        logic              last;
    } frame_item_t;

    typedef struct {
        sample_t fund;
        sample_t prime;
        sample_t comp;
        logic    hop_last;
    } synth_item_t;

    class wola_scoreboard;
        longint          chan_sum[NUM_CH][FRAME_LEN];
        longint unsigned wsq_sum[FRAME_LEN];
        int unsigned     position;
        int unsigned     hop;
        longint unsigned gain;
        synth_item_t     expected_q[$];
        int              errors;

        function new();
            clear_overlap();
            hop = wola3_pkg::HOP_RESET;
            gain = wola3_pkg::GAIN_RESET;
            errors = 0;
        endfunction

        function void clear_overlap();
            for (int i = 0; i < FRAME_LEN; i++)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    chan_sum[c][i] = 0;
                wsq_sum[i] = 0;
            end
            position = 0;
        endfunction

        function void set_reg(wola3_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                wola3_pkg::REG_HOP_SIZE:    hop = data[HOP_W-1:0];
                wola3_pkg::REG_OUTPUT_GAIN: gain = data;
                default:                    ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function longint sat_sum(longint v);
            if (v > longint'(wola3_pkg::SUM_MAX))
                return wola3_pkg::SUM_MAX;
            if (v < longint'(wola3_pkg::SUM_MIN))
                return wola3_pkg::SUM_MIN;
            return v;
        endfunction

        // Rounds half away from zero on the magnitude, then saturates to 16 bits.
        function sample_t scale_out(longint s, longint unsigned norm);
            longint unsigned mag;
            longint unsigned q;
            mag = (s < 0) ? -s : s;
            q = (mag * gain * 16 + norm / 2) / norm;
            if (s < 0)
                return (q > wola3_pkg::Q_NEG_LIMIT) ? wola3_pkg::OUT_MIN
                                                    : sample_t'(-longint'(q));
            return (q > wola3_pkg::Q_POS_LIMIT) ? wola3_pkg::OUT_MAX : sample_t'(q);
        endfunction

        function void take_sample(frame_item_t it);
            int unsigned     n;
            int unsigned     src;
            longint          prior[NUM_CH];
            longint          x[NUM_CH];
            longint          w;
            longint unsigned prior_wsq;
            longint unsigned wsq;
            longint unsigned norm;
            synth_item_t     r;
            if (it.op == wola3_pkg::OP_CLEAR)
            begin
                clear_overlap();
                return;
            end
            n = position;
            src = n + hop;
            if (n < hop)
            begin
                norm = wsq_sum[n];
                if (norm <= wola3_pkg::NORM_FLOOR)
                    norm = wola3_pkg::NORM_ONE;
                r.fund = scale_out(chan_sum[0][n], norm);
                r.prime = scale_out(chan_sum[1][n], norm);
                r.comp = scale_out(chan_sum[2][n], norm);
                r.hop_last = (n + 1 == hop) || it.last || (n + 1 >= FRAME_LEN);
                expected_q = {expected_q, r};
            end
            x[0] = it.fund;
            x[1] = it.prime;
            x[2] = it.comp;
            w = it.coef;
            prior_wsq = 0;
            for (int c = 0; c < NUM_CH; c++)
                prior[c] = 0;
            // The shifted-in value comes from one hop further on, or is zero past the end.
            if (src < FRAME_LEN)
            begin
                for (int c = 0; c < NUM_CH; c++)
                    prior[c] = chan_sum[c][src];
                prior_wsq = wsq_sum[src];
            end
            for (int c = 0; c < NUM_CH; c++)
                chan_sum[c][n] = sat_sum(prior[c] + x[c] * w);
            wsq = prior_wsq + w * w;
            wsq_sum[n] = (wsq > wola3_pkg::WSQ_MAX) ? wola3_pkg::WSQ_MAX : wsq;
            position = (it.last || n + 1 >= FRAME_LEN) ? 0 : n + 1;
        endfunction

        function void check_field(string name, logic signed [31:0] want,
                                  logic signed [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0d, actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_output(synth_item_t got);
            synth_item_t want;
            if (expected_q.size() == 0)
            begin
                $error({"Output item with none expected: ",
                        "fund_out=%0d prime_out=%0d comp_out=%0d hop_last=%0b"},
                       got.fund, got.prime, got.comp, got.hop_last);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            check_field("fund_out", want.fund, got.fund);
            check_field("prime_out", want.prime, got.prime);
            check_field("comp_out", want.comp, got.comp);
            check_field("hop_last", want.hop_last, got.hop_last);
        endfunction
    endclass

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    wola3_pkg::op_t        op = wola3_pkg::OP_SAMPLE;
    sample_t               fund_in = '0;
    sample_t               prime_in = '0;
    sample_t               comp_in = '0;
    logic [COEF_W-1:0]     window_coef = '0;
    logic                  frame_last = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    sample_t               fund_out;
    sample_t               prime_out;
    sample_t               comp_out;
    logic                  hop_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    wola3_pkg::cfg_reg_t   cfg_index = wola3_pkg::REG_HOP_SIZE;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    bit             hold_request = 1'b0;
    bit             last_item_clear = 1'b0;
    int             items_sent = 0;
    int             burst_left = 0;
    wola_scoreboard sb = new();

    weighted_overlap_add_three_channel_unit u_top (.*);

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        if (out_valid && out_ready)
            sb.check_output(synth_item_t'{fund_out, prime_out, comp_out, hop_last});
    end

    // Output side: runs of ready and stall of random length, plus one long hold on request.
    initial
    begin
        int   run_left;
        logic level;
        run_left = 0;
        level = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                run_left = 0;
            end
            if (run_left == 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4:
                    begin
                        level = 1'b1;
                        run_left = $urandom_range(1, 20);
                    end
                    5, 6, 7:
                    begin
                        level = 1'b0;
                        run_left = $urandom_range(1, 8);
                    end
                    default:
                    begin
                        level = 1'b1;
                        run_left = $urandom_range(40, 150);
                    end
                endcase
            end
            out_ready <= level;
            run_left--;
        end
    end

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 7))
            0:       return wola3_pkg::OUT_MAX;
            1:       return wola3_pkg::OUT_MIN;
            2:       return sample_t'(int'($urandom_range(0, 64)) - 32);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return COEF_W'($urandom_range(1, 255));
            default: return COEF_W'($urandom);
        endcase
    endfunction

    function automatic frame_item_t rand_item(wola3_pkg::op_t kind);
        frame_item_t it;
        it.op = kind;
        it.fund = rand_sample();
        it.prime = rand_sample();
        it.comp = rand_sample();
        it.coef = rand_coef();
        it.last = 1'($urandom_range(0, 1));
        return it;
    endfunction

    task automatic send_item(frame_item_t it);
        in_valid    <= 1'b1;
        op          <= it.op;
        fund_in     <= it.fund;
        prime_in    <= it.prime;
        comp_in     <= it.comp;
        window_coef <= it.coef;
        frame_last  <= it.last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.take_sample(it);
        last_item_clear = (it.op == wola3_pkg::OP_CLEAR);
        items_sent++;
    endtask

    // Input side works in bursts; a gap ends every burst.
    task automatic pace();
        if (burst_left > 0)
        begin
            burst_left--;
            return;
        end
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 25)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                 : $urandom_range(0, 12);
    endtask

    task automatic push_sample(int f, int p, int c, int w, bit last);
        frame_item_t it;
        it.op = wola3_pkg::OP_SAMPLE;
        it.fund = sample_t'(f);
        it.prime = sample_t'(p);
        it.comp = sample_t'(c);
        it.coef = w[COEF_W-1:0];
        it.last = last;
        send_item(it);
        pace();
    endtask

    task automatic push_clear();
        send_item(rand_item(wola3_pkg::OP_CLEAR));
        pace();
    endtask

    task automatic send_frame(int len, bit quiet_window, bit ends);
        frame_item_t it;
        for (int i = 0; i < len; i++)
        begin
            it = rand_item(wola3_pkg::OP_SAMPLE);
            if (quiet_window)
                it.coef = COEF_W'($urandom_range(0, 64));
            it.last = ends && (i == len - 1);
            send_item(it);
            pace();
        end
    endtask

    // Holds the input until every expected output has come, then lets any item
    // without an output, or a clearing pass, run out.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (last_item_clear ? FRAME_LEN + SETTLE_CYC : SETTLE_CYC)
            @(posedge clk);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] hop_data,
                             logic [CFG_DATA_W-1:0] gain_data);
        cfg_valid <= 1'b1;
        cfg_index <= wola3_pkg::REG_HOP_SIZE;
        cfg_data  <= hop_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(wola3_pkg::REG_HOP_SIZE, hop_data);
        cfg_index <= wola3_pkg::REG_OUTPUT_GAIN;
        cfg_data  <= gain_data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_reg(wola3_pkg::REG_OUTPUT_GAIN, gain_data);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_phase();
        logic [CFG_DATA_W-1:0] hop_data;
        logic [CFG_DATA_W-1:0] gain_data;
        int unsigned           hop_now;
        int                    frames;
        int                    pick;
        int                    len;
        case ($urandom_range(0, 19))
            0:       hop_data = '0;
            1:       hop_data = 16'd1024;
            2:       hop_data = CFG_DATA_W'($urandom);
            3, 4:    hop_data = CFG_DATA_W'($urandom_range(17, 48));
            default: hop_data = CFG_DATA_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 7))
            0:       gain_data = '0;
            1:       gain_data = '1;
            2, 3:    gain_data = wola3_pkg::GAIN_RESET;
            default: gain_data = CFG_DATA_W'($urandom);
        endcase
        settle();
        configure(hop_data, gain_data);
        if ($urandom_range(0, 3) == 0)
            push_clear();
        hop_now = hop_data[HOP_W-1:0];
        frames = $urandom_range(2, 6);
        for (int f = 0; f < frames; f++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
                push_clear();
            // Mostly whole frames of a few hops; the rest are cut short or left open.
            if (pick < 7 && hop_now != 0 && hop_now <= 48)
                len = hop_now * $urandom_range(1, 4);
            else
                len = $urandom_range(1, 40);
            send_frame(len, $urandom_range(0, 9) == 0, pick != 9);
        end
    endtask

    initial
    begin
        int random_start;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        configure(16'd2, wola3_pkg::GAIN_RESET);
        push_sample(32767, -32768, 0, 65535, 1'b0);
        push_sample(-32768, 32767, -1, 65535, 1'b0);
        push_sample(1, -1, 12345, 0, 1'b0);
        push_sample(-2, 100, -32768, 1, 1'b1);
        settle();
        configure(16'd2, 16'hFFFF);
        push_sample(100, -100, 32767, 65535, 1'b0);
        push_sample(0, 0, 0, 40, 1'b0);
        push_sample(7, -7, 3, 30000, 1'b0);
        push_sample(-32768, 32767, 32767, 65535, 1'b1);
        settle();
        configure(16'd2, 16'd0);
        push_sample(5, 5, 5, 5, 1'b0);
        push_sample(-5, -5, -5, 5, 1'b1);
        push_clear();
        settle();
        // Tiny windows keep the window-square sum at or below the floor.
        configure(16'd3, wola3_pkg::GAIN_RESET);
        push_sample(32767, -32768, 1000, 60, 1'b0);
        push_sample(-32768, 32767, -1000, 50, 1'b1);
        push_sample(12, -12, 0, 65535, 1'b0);
        push_sample(300, -300, 77, 2, 1'b0);
        push_sample(-1, 1, 32767, 65535, 1'b1);
        settle();
        configure(16'd0, wola3_pkg::GAIN_RESET);
        push_sample(32767, 32767, 32767, 65535, 1'b1);
        push_sample(-32768, -32768, -32768, 65535, 1'b1);
        settle();
        // The upper bits drop out and the hop reads as 2047, past the frame end.
        configure(16'hFFFF, wola3_pkg::GAIN_RESET);
        push_sample(-32768, 32767, 1, 65535, 1'b0);
        push_sample(32767, -32768, -1, 32768, 1'b0);
        push_sample(0, 0, 0, 0, 1'b1);

        // With a zero hop each item adds in place at position zero until the sums saturate.
        settle();
        configure(16'd0, 16'hFFFF);
        repeat (300) push_sample(32767, -32768, 32767, 65535, 1'b1);
        settle();
        configure(16'd1, 16'hFFFF);
        push_sample(0, 0, 0, 0, 1'b1);

        // The output side holds off for a long stretch while items keep coming.
        settle();
        configure(16'd8, wola3_pkg::GAIN_RESET);
        hold_request = 1'b1;
        send_frame(64, 1'b0, 1'b1);

        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS)
            random_phase();

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #1_500_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/wola3_pkg.sv
sv/weighted_overlap_add_three_channel_unit.sv
tb/sv/tb_weighted_overlap_add_three_channel_unit.sv
